@@ rtl/core/acf_pkg.sv @@
// shared constants and types for the ascii command framer
// no dependencies
`default_nettype none
package acf_pkg;

   localparam int BUF_DEPTH = 64;
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int ADDR_W    = $clog2(BUF_DEPTH);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_STX    = 8'h02;
   localparam logic [7:0] CH_ETX    = 8'h03;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_ASSIGN = 8'h3D;
   localparam logic [7:0] CH_QUERY  = 8'h3F;
   localparam logic [7:0] CH_NONE   = 8'hFF;

   localparam logic [1:0] CMD_GET = 2'd0;
   localparam logic [1:0] CMD_SET = 2'd1;
   localparam logic [1:0] CMD_BAD = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_EMIT_RD,
      ST_EMIT_WR,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic [1:0] cmd_type;
      logic       part;
      logic [7:0] char_out;
      logic       last;
   } beat_type;

endpackage
`default_nettype wire

@@ rtl/core/acf_ram.sv @@
// generic single write, single read port ram with registered read
// no dependencies
`default_nettype none
module acf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/acf_ctrl.sv @@
// byte intake, marker scan and result sequencing over the line store
// depends on acf_pkg and acf_ram
`default_nettype none
module acf_ctrl import acf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       out_free,
   output logic            beat_load,
   output beat_type        beat
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] byte_ff, byte_in;
   logic             cr_ff, cr_in;
   logic             stx_ff, stx_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             set_ff, set_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   acf_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         byte_ff  <= '0;
         cr_ff    <= 1'b0;
         stx_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         byte_ff  <= byte_in;
         cr_ff    <= cr_in;
         stx_ff   <= stx_in;
      end
      n_ff   <= n_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      set_ff <= set_in;
   end

   logic [CNT_W-1:0] bc;
   logic             ovf;
   logic             in_name;
   logic             name_end;

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      byte_in   = byte_ff;
      cr_in     = cr_ff;
      stx_in    = stx_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      set_in    = set_ff;
      req_stall = (state_ff != ST_IDLE);
      wr_en     = 1'b0;
      wr_addr   = fill_ff[ADDR_W-1:0];
      wr_data   = req_rx_byte;
      rd_en     = 1'b0;
      rd_addr   = idx_ff[ADDR_W-1:0];
      beat_load = 1'b0;
      beat      = '0;
      bc        = byte_ff + CNT_W'(1);
      ovf       = (bc >= CNT_W'(BUF_DEPTH));
      in_name   = (idx_ff < pos_ff);
      name_end  = (idx_ff + CNT_W'(1) == pos_ff)
                  && (!set_ff || (pos_ff + CNT_W'(1) >= n_ff));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // overflow clear comes before the byte is handled
               byte_in = ovf ? '0 : bc;
               if (ovf) begin
                  fill_in = '0;
                  cr_in   = 1'b0;
                  stx_in  = 1'b0;
               end
               priority if (req_rx_byte == CH_NONE) begin
               end else if (req_rx_byte == CH_CR) begin
                  cr_in = 1'b1;
               end else if (req_rx_byte == CH_STX) begin
                  fill_in = '0;
                  byte_in = '0;
                  cr_in   = 1'b0;
                  stx_in  = 1'b1;
               end else if ((req_rx_byte == CH_LF && cr_in)
                            || (req_rx_byte == CH_ETX && stx_in)) begin
                  n_in    = fill_in;
                  idx_in  = fill_in - CNT_W'(1);
                  state_in = (fill_in <= CNT_W'(1)) ? ST_BAD : ST_SCAN_RD;
                  fill_in = '0;
                  byte_in = '0;
                  cr_in   = 1'b0;
                  stx_in  = 1'b0;
               end else begin
                  cr_in = 1'b0;
                  if (req_rx_byte != CH_NUL) begin
                     wr_en   = 1'b1;
                     wr_addr = fill_in[ADDR_W-1:0];
                     fill_in = fill_in + CNT_W'(1);
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            priority if (rd_data == CH_QUERY || rd_data == CH_ASSIGN) begin
               pos_in   = idx_ff;
               set_in   = (rd_data == CH_ASSIGN);
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else if (idx_ff == CNT_W'(1)) begin
               state_in = ST_BAD;
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               beat_load     = 1'b1;
               beat.cmd_type = set_ff ? CMD_SET : CMD_GET;
               beat.part     = !in_name;
               beat.char_out = rd_data;
               if (in_name) begin
                  beat.last = name_end;
                  priority if (name_end) begin
                     state_in = ST_IDLE;
                  end else if (idx_ff + CNT_W'(1) == pos_ff) begin
                     idx_in   = pos_ff + CNT_W'(1);
                     state_in = ST_EMIT_RD;
                  end else begin
                     idx_in   = idx_ff + CNT_W'(1);
                     state_in = ST_EMIT_RD;
                  end
               end else begin
                  beat.last = (idx_ff + CNT_W'(1) == n_ff);
                  idx_in    = idx_ff + CNT_W'(1);
                  state_in  = beat.last ? ST_IDLE : ST_EMIT_RD;
               end
            end
         end
         ST_BAD: begin
            if (out_free) begin
               beat_load     = 1'b1;
               beat.cmd_type = CMD_BAD;
               beat.last     = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/ascii_command_framer_top.sv @@
// an ending byte starts a backward scan of the line store, a read and a check per entry;
// each result is then a line store read and a load of the output register (an invalid
// result needs no read), and a load waits while the output is stalled
// throughput: one byte per cycle while idle; no byte is taken while results are sequenced
// reset: synchronous, active high; clears counts, flags and the output valid
// top level of the ascii command framer, holds the result output register
// depends on acf_pkg and acf_ctrl
`default_nettype none
module ascii_command_framer_top import acf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_cmd_type,
   output logic            rsp_part,
   output logic [7:0]      rsp_char_out,
   output logic            rsp_last
);

   logic     rsp_valid_ff;
   beat_type beat_ff;
   beat_type beat;
   logic     beat_load;
   logic     out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   acf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .beat_load   (beat_load),
      .beat        (beat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (beat_load) begin
         beat_ff <= beat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cmd_type = beat_ff.cmd_type;
   assign rsp_part     = beat_ff.part;
   assign rsp_char_out = beat_ff.char_out;
   assign rsp_last     = beat_ff.last;

endmodule
`default_nettype wire
